// ===== rtl/core/u2a_pkg.sv =====
// Package for the radix to ASCII converter: request and character types,
// controller states, command and status structs and the radix decode and glyph functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package u2a_pkg;

	localparam int unsigned ValueW = 16;
	localparam int unsigned BaseW = 8;
	localparam int unsigned CharW = 7;
	localparam int unsigned DigitW = 4;
	localparam int unsigned MaxDigits = 16;
	localparam int unsigned PtrW = $clog2(MaxDigits);

	localparam logic [BaseW-1:0] BASE_BIN = 8'd2;
	localparam logic [BaseW-1:0] BASE_DEC = 8'd10;
	localparam logic [BaseW-1:0] BASE_HEX = 8'd16;

	// Reciprocal of ten scaled by 2^19, exact for every 16-bit dividend.
	localparam logic [16:0] RECIP_TEN = 17'd52429;
	localparam int unsigned RECIP_SHIFT = 19;

	localparam logic [CharW-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CharW-1:0] CHAR_ALPHA = 7'd55;

	typedef struct packed {
		logic [ValueW-1:0] value;
		logic [BaseW-1:0]  base;
	} req_t;

	typedef struct packed {
		logic [CharW-1:0] char_code;
		logic             last;
	} char_t;

	typedef enum logic [1:0] {
		RADIX_BIN,
		RADIX_DEC,
		RADIX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic quot_zero;
		logic ptr_zero;
		logic out_free;
	} status_t;

	function automatic radix_t decode_radix(input logic [BaseW-1:0] base);
		radix_t r;
		case (base)
			BASE_BIN: r = RADIX_BIN;
			BASE_HEX: r = RADIX_HEX;
			default:  r = RADIX_DEC;
		endcase
		return r;
	endfunction

	function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] d);
		logic [CharW-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'd0, d};
		end else begin
			c = CHAR_ALPHA + {3'd0, d};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/u2a_ctrl.sv =====
// Controller state machine for the radix to ASCII converter.
// Depends on u2a_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module u2a_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  u2a_pkg::status_t status,
	output u2a_pkg::cmd_t    cmd
);
	import u2a_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (status.quot_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.ptr_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_conv_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && status.quot_zero) |=> state_q == ST_EMIT)
		else $error("conversion did not hand over to emission");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.ptr_zero) |=> (state_q == ST_IDLE && !req_stall))
		else $error("controller did not return to idle after the last character");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ST_IDLE && req_valid))
		else $error("load issued outside idle");

endmodule
`default_nettype wire

// ===== rtl/core/u2a_dp.sv =====
// Datapath for the radix to ASCII converter: value register, digit step,
// digit buffer and the character output register.
// Depends on u2a_pkg for the payload, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module u2a_dp (
	input  wire              clk,
	input  wire              arst_n,
	input  u2a_pkg::req_t    req_data,
	input  u2a_pkg::cmd_t    cmd,
	output u2a_pkg::status_t status,
	output logic             char_valid,
	input  wire              char_stall,
	output u2a_pkg::char_t   char_data
);
	import u2a_pkg::*;

	logic [ValueW-1:0] num_q;
	radix_t            radix_q;
	logic [DigitW-1:0] digit_q [MaxDigits];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   ptr_q;
	logic              valid_q;
	char_t             out_q;

	logic [32:0]       prod;
	logic [12:0]       quot_dec;
	logic [ValueW-1:0] quot;
	logic [DigitW-1:0] rem;
	logic [ValueW-1:0] back;

	always_comb begin
		prod = {17'd0, num_q} * {16'd0, RECIP_TEN};
		quot_dec = prod[RECIP_SHIFT+12:RECIP_SHIFT];
		back = {quot_dec, 3'd0} + {2'd0, quot_dec, 1'b0};
		case (radix_q)
			RADIX_BIN: begin
				quot = {1'b0, num_q[ValueW-1:1]};
				rem = {3'd0, num_q[0]};
			end
			RADIX_HEX: begin
				quot = {4'd0, num_q[ValueW-1:4]};
				rem = num_q[3:0];
			end
			default: begin
				quot = {3'd0, quot_dec};
				rem = DigitW'(num_q - back);
			end
		endcase
	end

	assign status.quot_zero = (quot == '0);
	assign status.ptr_zero = (ptr_q == '0);
	assign status.out_free = !valid_q || !char_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= req_data.value;
			radix_q <= decode_radix(req_data.base);
		end else if (cmd.step) begin
			num_q <= quot;
			digit_q[wr_q] <= rem;
		end
		if (cmd.emit) begin
			out_q.char_code <= glyph(digit_q[ptr_q]);
			out_q.last <= (ptr_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			ptr_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				wr_q <= '0;
			end else if (cmd.step) begin
				wr_q <= wr_q + 1'b1;
				if (quot == '0) begin
					ptr_q <= wr_q;
				end
			end else if (cmd.emit) begin
				ptr_q <= ptr_q - 1'b1;
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (!char_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign char_valid = valid_q;
	assign char_data = out_q;

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((out_q.char_code >= 7'd48 && out_q.char_code <= 7'd57) ||
			(out_q.char_code >= 7'd65 && out_q.char_code <= 7'd70)))
		else $error("character outside the digit set");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.emit}))
		else $error("more than one datapath command at once");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!valid_q || !char_stall))
		else $error("character overwritten while stalled");

endmodule
`default_nettype wire

// ===== rtl/core/unsigned_to_ascii_radix_core.sv =====
// Top level of the radix to ASCII converter: controller plus datapath.
// Depends on u2a_pkg, u2a_ctrl and u2a_dp.
//
// A request on req_data carries a 16-bit unsigned value and a base selector;
// base 2, 10 or 16 selects that radix and any other code selects 10. The block
// answers with one character per digit on char_data, most significant digit
// first, upper-case hex letters, no leading zeros, and a zero value gives a
// single '0'. The final character of each run has last set.
// Both channels use valid and stall; a transfer happens on a rising edge with
// valid high and stall low. req_stall is low only while the controller idles.
// For a value of n digits the block takes the request, runs the digit loop
// (one shift or one reciprocal multiply per digit) and then moves the digits
// from the buffer to the output register; req_stall stays high until the last
// digit has been moved. A stalled character holds in the output register and
// emission waits; the next request may be taken while the last character of a
// run still waits. Reset clears the controller, the buffer pointers and the
// output valid; the value and digit buffers need no reset.
`timescale 1ns / 1ps
`default_nettype none
module unsigned_to_ascii_radix_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  u2a_pkg::req_t   req_data,
	output logic            char_valid,
	input  wire             char_stall,
	output u2a_pkg::char_t  char_data
);
	import u2a_pkg::*;

	cmd_t    cmd;
	status_t status;

	u2a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	u2a_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_data   (req_data),
		.cmd        (cmd),
		.status     (status),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

endmodule
`default_nettype wire
